/* rtl/core/ps2_keyboard_controller_core_assert.svh */
// assertion helpers included by ps2_keyboard_controller_core
`ifndef PS2_KEYBOARD_CONTROLLER_CORE_ASSERT_SVH
`define PS2_KEYBOARD_CONTROLLER_CORE_ASSERT_SVH

// antecedent implies consequent in the same cycle
`define PS2KC_ASSERT_NOW(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) else $error(msg);

// antecedent implies consequent in the next cycle
`define PS2KC_ASSERT_NEXT(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) else $error(msg);

`endif

/* rtl/core/ps2kc_pkg.sv */
`default_nettype none

package ps2kc_pkg;

  typedef struct packed {
    logic [1:0] op;
    logic [2:0] offset;
    logic [7:0] write_data;
    logic [7:0] key_char;
  } req_t;

  typedef struct packed {
    logic [7:0] read_data;
    logic       irq_pending;
    logic       bad_offset;
    logic       fifo_overflow;
  } rsp_t;

  typedef struct packed {
    logic       mapped;
    logic       last;
    logic [7:0] code;
  } key_code_t;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_EXEC,
    ST_PUSH,
    ST_RDWAIT,
    ST_POLL,
    ST_FINISH
  } state_t;

  localparam logic [1:0] OP_READ  = 2'd0;
  localparam logic [1:0] OP_WRITE = 2'd1;
  localparam logic [1:0] OP_KEY   = 2'd2;

  localparam logic [2:0] OFF_DATA = 3'd0;
  localparam logic [2:0] OFF_CTRL = 3'd4;

  localparam logic [1:0] RESP_NONE       = 2'd0;
  localparam logic [1:0] RESP_PENDING    = 2'd1;
  localparam logic [1:0] RESP_RESET_DONE = 2'd2;

  // controller commands
  localparam logic [7:0] CMD_READ_CB     = 8'h20;
  localparam logic [7:0] CMD_WRITE_CB    = 8'h60;
  localparam logic [7:0] CMD_SELF_TEST   = 8'hAA;
  localparam logic [7:0] CMD_IF_TEST     = 8'hAB;
  localparam logic [7:0] CMD_KBD_DISABLE = 8'hAD;
  localparam logic [7:0] CMD_KBD_ENABLE  = 8'hAE;

  // keyboard commands and answers
  localparam logic [7:0] KBD_CMD_RESET   = 8'hFF;
  localparam logic [7:0] KBD_DISABLE     = 8'hF5;
  localparam logic [7:0] KBD_ENABLE      = 8'hF4;
  localparam logic [7:0] KBD_ACK         = 8'hFA;
  localparam logic [7:0] KBD_BAT_OK      = 8'hAA;
  localparam logic [7:0] SELF_TEST_OK    = 8'h55;

  localparam logic [7:0] CB_RESET        = 8'h65;
  localparam logic [7:0] STATUS_FIXED    = 8'h10;

  localparam logic [7:0] SC_LSHIFT_MAKE  = 8'h2A;
  localparam logic [7:0] SC_LSHIFT_BREAK = 8'hAA;
  localparam logic [7:0] SC_BREAK_BIT    = 8'h80;

  // bit7 shift needed, bits 6..0 make code, zero means unmapped
  localparam logic [7:0] KEY_ROM [128] = '{
    8'h00,8'h00,8'h00,8'h00,8'h00,8'h00,8'h00,8'h00,
    8'h0E,8'h0F,8'h1C,8'h00,8'h00,8'h00,8'h00,8'h00,
    8'h00,8'h00,8'h00,8'h00,8'h00,8'h00,8'h00,8'h00,
    8'h00,8'h00,8'h00,8'h01,8'h00,8'h00,8'h00,8'h00,
    8'h39,8'h82,8'hA8,8'h84,8'h85,8'h86,8'h88,8'h28,
    8'h8A,8'h8B,8'h89,8'h8D,8'h33,8'h0C,8'h34,8'h35,
    8'h0B,8'h02,8'h03,8'h04,8'h05,8'h06,8'h07,8'h08,
    8'h09,8'h0A,8'hA7,8'h27,8'hB3,8'h0D,8'hB4,8'hB5,
    8'h83,8'h9E,8'hB0,8'hAE,8'hA0,8'h92,8'hA1,8'hA2,
    8'hA3,8'h97,8'hA4,8'hA5,8'hA6,8'hB2,8'hB1,8'h98,
    8'h99,8'h90,8'h93,8'h9F,8'h94,8'h96,8'hAF,8'h91,
    8'hAD,8'h95,8'hAC,8'h1A,8'h2B,8'h1B,8'h87,8'h8C,
    8'h29,8'h1E,8'h30,8'h2E,8'h20,8'h12,8'h21,8'h22,
    8'h23,8'h17,8'h24,8'h25,8'h26,8'h32,8'h31,8'h18,
    8'h19,8'h10,8'h13,8'h1F,8'h14,8'h16,8'h2F,8'h11,
    8'h2D,8'h15,8'h2C,8'h9A,8'hAB,8'h9B,8'hA9,8'h00
  };

endpackage

`default_nettype wire

/* rtl/core/ps2_keyboard_controller_core.sv */
`default_nettype none

// Simplified 8042 keyboard controller. Each word on req is a register read, a
// register write (offset 0 data, 4 control/status) or an ASCII key character,
// and gives exactly one word on rsp. Scan codes sit in a FIFO_DEPTH x 8
// single-port-write memory with a registered read. An item passes from IDLE
// (acceptance) through EXEC to FINISH; a data read that pops the FIFO goes
// through RDWAIT for the memory read, a key character that maps to no scan
// code goes through POLL, and a mapped key character goes through PUSH, where
// 2 or 4 scan codes are written one per cycle through the memory write port,
// and then POLL. The response is loaded in FINISH; if the rsp register still
// holds an earlier word under stall, the block waits there until it frees.
// A finished word waits in the rsp register while the next item is accepted.
module ps2_keyboard_controller_core #(
  parameter int FIFO_DEPTH = 256
) (
  input  wire logic            clk,
  input  wire logic            rst,
  input  wire logic            req_valid,
  output logic                 req_stall,
  input  wire ps2kc_pkg::req_t req,
  output logic                 rsp_valid,
  input  wire logic            rsp_stall,
  output ps2kc_pkg::rsp_t      rsp
);

  localparam int AddrW = (FIFO_DEPTH > 1) ? $clog2(FIFO_DEPTH) : 1;
  localparam int CntW  = $clog2(FIFO_DEPTH + 1);

  ps2kc_pkg::state_t    state, state_next;
  ps2kc_pkg::req_t      cur;
  ps2kc_pkg::key_code_t key_code;

  logic [AddrW-1:0] fifo_head, fifo_tail;
  logic [CntW-1:0]  fifo_count;
  logic [7:0]       controller_command, keyboard_command, command_byte;
  logic [1:0]       response_state;
  logic             irq_flag;
  logic [1:0]       push_idx;
  logic [7:0]       res_read_data;
  logic             res_bad, res_ovf;

  logic             mem_we, mem_re;
  logic [7:0]       mem_rdata;
  logic             fifo_full, fifo_empty, pending;
  logic             offset_ok, is_pop, rsp_free;
  logic [7:0]       status_byte, cc_answer, kc_eff, cb_written;

  assign fifo_full  = (fifo_count >= CntW'(FIFO_DEPTH));
  assign fifo_empty = (fifo_count == '0);
  assign pending    = (response_state != ps2kc_pkg::RESP_NONE) || !fifo_empty;
  assign offset_ok  = (cur.offset == ps2kc_pkg::OFF_DATA) ||
                      (cur.offset == ps2kc_pkg::OFF_CTRL);
  assign is_pop     = (cur.op == ps2kc_pkg::OP_READ) && (cur.offset == ps2kc_pkg::OFF_DATA) &&
                      (controller_command == 8'h00) &&
                      (response_state == ps2kc_pkg::RESP_NONE) && !fifo_empty;
  assign rsp_free   = !rsp_valid || !rsp_stall;

  assign status_byte = ps2kc_pkg::STATUS_FIXED | {5'd0, command_byte[2], 1'b0, pending};

  always_comb begin
    case (controller_command)
      ps2kc_pkg::CMD_READ_CB:   cc_answer = command_byte;
      ps2kc_pkg::CMD_SELF_TEST: cc_answer = ps2kc_pkg::SELF_TEST_OK;
      default:                  cc_answer = 8'h00;
    endcase
  end

  // data write: byte lands in command byte after 0x60, else in keyboard command
  always_comb begin
    if (controller_command == ps2kc_pkg::CMD_WRITE_CB) begin
      kc_eff     = keyboard_command;
      cb_written = cur.write_data;
    end else begin
      kc_eff     = cur.write_data;
      cb_written = command_byte;
    end
    if (kc_eff == ps2kc_pkg::KBD_DISABLE) cb_written[4] = 1'b1;
    if (kc_eff == ps2kc_pkg::KBD_ENABLE)  cb_written[4] = 1'b0;
  end

  ps2kc_key_enc u_key_enc (
    .key_char (cur.key_char),
    .idx      (push_idx),
    .key_code (key_code)
  );

  ps2kc_scan_mem #(
    .Depth (FIFO_DEPTH)
  ) u_scan_mem (
    .clk   (clk),
    .we    (mem_we),
    .waddr (fifo_head),
    .wdata (key_code.code),
    .re    (mem_re),
    .raddr (fifo_tail),
    .rdata (mem_rdata)
  );

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= ps2kc_pkg::ST_IDLE;
    end else begin
      state <= state_next;
    end
  end

  always_comb begin
    state_next = state;
    req_stall  = 1'b1;
    mem_we     = 1'b0;
    mem_re     = 1'b0;
    unique case (state)
      ps2kc_pkg::ST_IDLE: begin
        req_stall = 1'b0;
        if (req_valid) state_next = ps2kc_pkg::ST_EXEC;
      end
      ps2kc_pkg::ST_EXEC: begin
        if (cur.op == ps2kc_pkg::OP_KEY) begin
          state_next = key_code.mapped ? ps2kc_pkg::ST_PUSH : ps2kc_pkg::ST_POLL;
        end else if (is_pop && offset_ok) begin
          mem_re     = 1'b1;
          state_next = ps2kc_pkg::ST_RDWAIT;
        end else begin
          state_next = ps2kc_pkg::ST_FINISH;
        end
      end
      ps2kc_pkg::ST_PUSH: begin
        mem_we = !fifo_full;
        if (key_code.last) state_next = ps2kc_pkg::ST_POLL;
      end
      ps2kc_pkg::ST_RDWAIT: state_next = ps2kc_pkg::ST_FINISH;
      ps2kc_pkg::ST_POLL:   state_next = ps2kc_pkg::ST_FINISH;
      ps2kc_pkg::ST_FINISH: begin
        if (rsp_free) state_next = ps2kc_pkg::ST_IDLE;
      end
      default: state_next = ps2kc_pkg::ST_IDLE;
    endcase
  end

  // payload registers
  always_ff @(posedge clk) begin
    if (state == ps2kc_pkg::ST_IDLE && req_valid) begin
      cur <= req;
    end
    if (state == ps2kc_pkg::ST_FINISH && rsp_free) begin
      rsp <= '{read_data: res_read_data, irq_pending: irq_flag,
               bad_offset: res_bad, fifo_overflow: res_ovf};
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      fifo_head          <= '0;
      fifo_tail          <= '0;
      fifo_count         <= '0;
      controller_command <= 8'h00;
      keyboard_command   <= 8'h00;
      command_byte       <= ps2kc_pkg::CB_RESET;
      response_state     <= ps2kc_pkg::RESP_NONE;
      irq_flag           <= 1'b0;
      push_idx           <= 2'd0;
      res_read_data      <= 8'h00;
      res_bad            <= 1'b0;
      res_ovf            <= 1'b0;
      rsp_valid          <= 1'b0;
    end else begin
      if (state == ps2kc_pkg::ST_FINISH && rsp_free) begin
        rsp_valid <= 1'b1;
      end else if (rsp_valid && !rsp_stall) begin
        rsp_valid <= 1'b0;
      end
      unique case (state)
        ps2kc_pkg::ST_IDLE: begin
          res_read_data <= 8'h00;
          res_bad       <= 1'b0;
          res_ovf       <= 1'b0;
          push_idx      <= 2'd0;
        end
        ps2kc_pkg::ST_EXEC: begin
          if ((cur.op == ps2kc_pkg::OP_READ || cur.op == ps2kc_pkg::OP_WRITE) && !offset_ok) begin
            res_bad <= 1'b1;
          end else if (cur.op == ps2kc_pkg::OP_READ) begin
            if (cur.offset == ps2kc_pkg::OFF_CTRL) begin
              res_read_data <= status_byte;
            end else begin
              irq_flag <= 1'b0;
              if (controller_command != 8'h00) begin
                res_read_data      <= cc_answer;
                controller_command <= 8'h00;
                response_state     <= ps2kc_pkg::RESP_NONE;
              end else if (response_state != ps2kc_pkg::RESP_NONE) begin
                keyboard_command <= 8'h00;
                if (response_state == ps2kc_pkg::RESP_RESET_DONE) begin
                  res_read_data  <= ps2kc_pkg::KBD_BAT_OK;
                  response_state <= ps2kc_pkg::RESP_NONE;
                end else begin
                  res_read_data  <= ps2kc_pkg::KBD_ACK;
                  // a reset command is followed by the BAT answer after its ack
                  response_state <= (keyboard_command == ps2kc_pkg::KBD_CMD_RESET) ?
                                    ps2kc_pkg::RESP_RESET_DONE : ps2kc_pkg::RESP_NONE;
                end
              end else if (!fifo_empty) begin
                fifo_tail  <= (fifo_tail == AddrW'(FIFO_DEPTH - 1)) ? '0 :
                              fifo_tail + AddrW'(1);
                fifo_count <= fifo_count - CntW'(1);
              end
            end
          end else if (cur.op == ps2kc_pkg::OP_WRITE) begin
            if (cur.offset == ps2kc_pkg::OFF_CTRL) begin
              controller_command <= cur.write_data;
              case (cur.write_data) inside
                ps2kc_pkg::CMD_READ_CB, ps2kc_pkg::CMD_SELF_TEST, ps2kc_pkg::CMD_IF_TEST:
                  response_state <= ps2kc_pkg::RESP_PENDING;
                ps2kc_pkg::CMD_KBD_DISABLE: begin
                  irq_flag        <= 1'b0;
                  command_byte[4] <= 1'b1;
                end
                ps2kc_pkg::CMD_KBD_ENABLE:
                  command_byte[4] <= 1'b0;
                default: ;
              endcase
            end else begin
              keyboard_command   <= kc_eff;
              command_byte       <= cb_written;
              response_state     <= ps2kc_pkg::RESP_PENDING;
              controller_command <= 8'h00;
            end
          end
        end
        ps2kc_pkg::ST_PUSH: begin
          push_idx <= push_idx + 2'd1;
          if (fifo_full) begin
            res_ovf <= 1'b1;
          end else begin
            fifo_head  <= (fifo_head == AddrW'(FIFO_DEPTH - 1)) ? '0 :
                          fifo_head + AddrW'(1);
            fifo_count <= fifo_count + CntW'(1);
          end
        end
        ps2kc_pkg::ST_RDWAIT: res_read_data <= mem_rdata;
        ps2kc_pkg::ST_POLL: begin
          if (pending && command_byte[0]) irq_flag <= 1'b1;
        end
        default: ;
      endcase
    end
  end

`include "ps2_keyboard_controller_core_assert.svh"

  `PS2KC_ASSERT_NOW(a_count_bound, 1'b1, fifo_count <= CntW'(FIFO_DEPTH), "fifo count past depth")
  `PS2KC_ASSERT_NOW(a_push_not_full, mem_we, !fifo_full, "scan code written into full fifo")
  `PS2KC_ASSERT_NOW(a_pop_not_empty, mem_re, !fifo_empty && !mem_we, "pop from empty fifo")
  `PS2KC_ASSERT_NEXT(a_finish_loads, state == ps2kc_pkg::ST_FINISH && rsp_free, rsp_valid && state == ps2kc_pkg::ST_IDLE, "finished word not presented")
  `PS2KC_ASSERT_NEXT(a_accept_exec, state == ps2kc_pkg::ST_IDLE && req_valid, state == ps2kc_pkg::ST_EXEC, "accepted word not executed")

endmodule

`default_nettype wire

/* rtl/core/ps2kc_scan_mem.sv */
`default_nettype none

module ps2kc_scan_mem #(
  parameter int Depth = 256,
  localparam int AddrW = (Depth > 1) ? $clog2(Depth) : 1
) (
  input  wire logic             clk,
  input  wire logic             we,
  input  wire logic [AddrW-1:0] waddr,
  input  wire logic [7:0]       wdata,
  input  wire logic             re,
  input  wire logic [AddrW-1:0] raddr,
  output logic      [7:0]       rdata
);

  logic [7:0] mem [Depth];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
  end

  always_ff @(posedge clk) begin
    if (re) begin
      rdata <= mem[raddr];
    end
  end

endmodule

`default_nettype wire

/* rtl/core/ps2kc_key_enc.sv */
`default_nettype none

module ps2kc_key_enc (
  input  wire logic [7:0]           key_char,
  input  wire logic [1:0]           idx,
  output ps2kc_pkg::key_code_t      key_code
);

  logic [7:0] rom;
  logic [7:0] make;

  assign rom  = ps2kc_pkg::KEY_ROM[key_char[6:0]];
  assign make = {1'b0, rom[6:0]};

  always_comb begin
    key_code.mapped = !key_char[7] && (rom[6:0] != 7'd0);
    if (rom[7]) begin
      // shifted character: shift make, make, break, shift break
      key_code.last = (idx == 2'd3);
      case (idx)
        2'd0:    key_code.code = ps2kc_pkg::SC_LSHIFT_MAKE;
        2'd1:    key_code.code = make;
        2'd2:    key_code.code = make | ps2kc_pkg::SC_BREAK_BIT;
        default: key_code.code = ps2kc_pkg::SC_LSHIFT_BREAK;
      endcase
    end else begin
      key_code.last = idx[0];
      key_code.code = idx[0] ? (make | ps2kc_pkg::SC_BREAK_BIT) : make;
    end
  end

endmodule

`default_nettype wire
